>>> hdl/mfsg_pkg.sv
// Package for the MUSE frame sample generator: register indexes, the
// configuration bundle and the region and level functions.
// No dependencies.
package mfsg_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_VITS_LOW   = 3'd0,
        CFG_VITS_HIGH  = 3'd1,
        CFG_CTRL_LOW   = 3'd2,
        CFG_CTRL_HIGH  = 3'd3,
        CFG_SYNC_LOW   = 3'd4,
        CFG_SYNC_HIGH  = 3'd5,
        CFG_CTRL_EXTRA = 3'd6
    } t_cfg_idx;

    // All configuration registers as one bundle
    typedef struct packed {
        logic [7:0]  vits_low;
        logic [7:0]  vits_high;
        logic [7:0]  ctrl_low;
        logic [7:0]  ctrl_high;
        logic [7:0]  sync_low;
        logic [7:0]  sync_high;
        logic [31:0] ctrl_extra;
    } t_cfg;

    localparam logic [7:0]  MID_LEVEL  = 8'd128;
    localparam logic [10:0] LINE_LAST  = 11'd1125;
    localparam logic [8:0]  PIX_LAST   = 9'd480;

    // Horizontal sync level of a pixel in the first ten
    function automatic logic [7:0] sync_level(input logic [10:0] line,
                                              input logic [8:0] pix,
                                              input t_cfg cfg);
        logic pos;
        pos = (line == 11'd1) || ((line > 11'd3) && !line[0]);
        if (pix == 9'd6)
            return MID_LEVEL;
        else if (pix <= 9'd5)
            return pos ? cfg.sync_low : cfg.sync_high;
        else
            return pos ? cfg.sync_high : cfg.sync_low;
    endfunction

    // One bit of a control signal group (Hamming(8,4) or the extra group)
    function automatic logic group_bit(input logic [4:0] g, input logic [2:0] b,
                                       input logic field, input logic parity,
                                       input t_cfg cfg);
        logic [31:0] w;
        logic [3:0]  d;
        w    = cfg.ctrl_extra;
        w[0] = field;
        w[8] = parity;
        w[9] = parity;
        d    = w[{g[2:0], 2'b00} +: 4];
        if (g == 5'd24) begin
            if (b < 3'd3)
                return w[19];
            else if (b < 3'd6)
                return w[8];
            else
                return w[9];
        end
        unique case (b)
            3'd0:    return d[0];
            3'd1:    return d[1];
            3'd2:    return d[2];
            3'd3:    return d[3];
            3'd4:    return d[0] ^ d[1] ^ d[2];
            3'd5:    return d[1] ^ d[2] ^ d[3];
            3'd6:    return d[0] ^ d[1] ^ d[3];
            default: return d[0] ^ d[2] ^ d[3];
        endcase
    endfunction

    // Level of pixels 12..480 of lines 1..1125
    function automatic logic [7:0] area_level(input logic [10:0] line,
                                              input logic [8:0] pix,
                                              input logic parity,
                                              input logic [7:0] luma,
                                              input t_cfg cfg);
        logic [7:0] v;
        logic [8:0] vdiff;
        logic       field;
        logic [2:0] rel;
        logic [8:0] off;
        logic [4:0] g;
        vdiff = pix - 9'd317;
        field = (line >= 11'd1121);
        rel   = field ? 3'(line - 11'd1121) : 3'(line - 11'd559);
        off   = pix - 9'd20;
        g     = 5'({2'b00, rel} * 5'd5) + {2'b00, off[6:4]};
        // test pattern lines
        if (line <= 11'd2) begin
            if (pix <= 9'd316)
                v = cfg.vits_high;
            else if (pix >= 9'd472)
                v = cfg.vits_low;
            else if (pix >= 9'd456)
                v = cfg.vits_high;
            else
                v = vdiff[2] ? cfg.vits_high : cfg.vits_low;
            return (line == 11'd2) ? ~v : v;
        end
        // control signal lines
        if ((line >= 11'd559 && line <= 11'd563) || field) begin
            if (pix == 9'd12)
                return 8'd0;
            if (pix <= 9'd19 || (pix >= 9'd100 && pix <= 9'd106))
                return MID_LEVEL;
            if (pix <= 9'd99)
                return group_bit(g, off[3:1], field, parity, cfg) ?
                       cfg.ctrl_high : cfg.ctrl_low;
            if (line == 11'd563 || line == LINE_LAST)
                return MID_LEVEL;
            return luma;
        end
        // picture lines
        if ((line >= 11'd47 && line <= 11'd558) || (line >= 11'd609 && line <= 11'd1120))
            return (pix >= 9'd107) ? luma : MID_LEVEL;
        return MID_LEVEL;
    endfunction

endpackage

>>> hdl/muse_frame_sample_generator_unit.sv
// Top level of the MUSE frame sample generator: input register, sample
// logic, result register and configuration registers.
// Depends on mfsg_pkg.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready): one raster position per word,
//   line 1..1125 and pixel 1..480 in raster order, with frame parity and
//   the luma level for that position.
//   Output channel (o_out_valid/i_out_ready): one sample per input word,
//   in half levels (0..510).
//   Config channel (i_cfg_valid/o_cfg_ready): register index and data;
//   always ready. Write only while no word is in flight.
// Path: an accepted word is held in the input register and then loaded
// into the result register, from which it leaves. Throughput: one word
// per cycle while i_out_ready stays high; the figure is set by the
// single sample stage between the two registers.
// Reset: sync, active low; clears both stages, restores register defaults
// and sets the stored line-end level to 128.
// Stall: when the receiver holds i_out_ready low the result register
// holds, the input register fills, and o_in_ready then drops.
module muse_frame_sample_generator_unit
    import mfsg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [10:0] i_line_number,
    input  logic [8:0]  i_pixel_number,
    input  logic        i_frame_parity,
    input  logic [7:0]  i_luma_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [8:0]  o_sample_half_levels,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic        r_in_valid;
    logic [10:0] r_in_line;
    logic [8:0]  r_in_pix;
    logic        r_in_parity;
    logic [7:0]  r_in_luma;
    logic        r_out_valid;
    logic [8:0]  r_out_sample;
    logic [7:0]  r_prev_end;
    t_cfg        r_cfg;
    logic [8:0]  n_sample;
    logic        advance;
    logic        in_fire;

    // handshake
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_sample_half_levels = r_out_sample;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vits_low   <= 8'd0;
            r_cfg.vits_high  <= 8'd255;
            r_cfg.ctrl_low   <= 8'd0;
            r_cfg.ctrl_high  <= 8'd255;
            r_cfg.sync_low   <= 8'd64;
            r_cfg.sync_high  <= 8'd192;
            r_cfg.ctrl_extra <= 32'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VITS_LOW:   r_cfg.vits_low   <= i_cfg_data[7:0];
                CFG_VITS_HIGH:  r_cfg.vits_high  <= i_cfg_data[7:0];
                CFG_CTRL_LOW:   r_cfg.ctrl_low   <= i_cfg_data[7:0];
                CFG_CTRL_HIGH:  r_cfg.ctrl_high  <= i_cfg_data[7:0];
                CFG_SYNC_LOW:   r_cfg.sync_low   <= i_cfg_data[7:0];
                CFG_SYNC_HIGH:  r_cfg.sync_high  <= i_cfg_data[7:0];
                CFG_CTRL_EXTRA: r_cfg.ctrl_extra <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_line   <= i_line_number;
            r_in_pix    <= i_pixel_number;
            r_in_parity <= i_frame_parity;
            r_in_luma   <= i_luma_level;
        end
    end

    // sample logic: edge pixels 1 and 11 sum their neighbors
    always_comb begin
        n_sample = 9'd0;
        if (r_in_line >= 11'd1 && r_in_line <= LINE_LAST &&
            r_in_pix >= 9'd1 && r_in_pix <= PIX_LAST) begin
            if (r_in_pix == 9'd1)
                n_sample = {1'b0, (r_in_line == 11'd1) ? MID_LEVEL : r_prev_end}
                         + {1'b0, sync_level(r_in_line, 9'd2, r_cfg)};
            else if (r_in_pix == 9'd11)
                n_sample = {1'b0, sync_level(r_in_line, 9'd10, r_cfg)}
                         + {1'b0, area_level(r_in_line, 9'd12, r_in_parity,
                                             r_in_luma, r_cfg)};
            else if (r_in_pix <= 9'd10)
                n_sample = {sync_level(r_in_line, r_in_pix, r_cfg), 1'b0};
            else
                n_sample = {area_level(r_in_line, r_in_pix, r_in_parity,
                                       r_in_luma, r_cfg), 1'b0};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_sample <= n_sample;
        end
    end

    // line-end level kept for pixel 1 of the next line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_end <= MID_LEVEL;
        end else if (advance && r_in_pix == PIX_LAST) begin
            r_prev_end <= n_sample[8:1];
        end
    end

    // checks
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    a_line_end_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_pix == PIX_LAST |=> r_prev_end == $past(n_sample[8:1]))
        else $error("line-end level not stored");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled without downstream stall");

    a_sample_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid && o_sample_half_levels == $past(n_sample))
        else $error("result register missed a sample");

endmodule
